// File: rtl/kcc_pkg.sv
package kcc_pkg;

  // Modulus and codec constants
  localparam int unsigned KyberQ = 3329;
  localparam logic [15:0] CompMult = 16'd20159;
  localparam logic [15:0] MsgMid = 16'((KyberQ - 1) / 2);
  localparam logic [15:0] MsgQuarter = 16'((KyberQ - 1) / 4);
  localparam logic [11:0] MsgHalf = 12'((KyberQ + 1) / 2);
  localparam logic [9:0] CompRound = 10'd32;
  localparam logic [15:0] DecRound = 16'd8;

  localparam int unsigned NumCoeff = 8;

  typedef enum logic [1:0] {
    OpCompress   = 2'd0,
    OpDecompress = 2'd1,
    OpMsgEncode  = 2'd2,
    OpMsgDecode  = 2'd3
  } op_e;

  // One message bit: sign of (1664 - x, inverted if negative) - 832, all in 16 bits
  function automatic logic msg_bit(input logic [15:0] x);
    logic [15:0] a;
    logic [15:0] b;
    a = MsgMid - x;
    if (a[15]) begin
      a = ~a;
    end
    b = a - MsgQuarter;
    return b[15];
  endfunction

  // Nibble to coefficient: (n*q + 8) >> 4
  function automatic logic [11:0] decompress4(input logic [3:0] n);
    logic [15:0] p;
    p = 16'(n) * 16'(KyberQ) + DecRound;
    return p[15:4];
  endfunction

  // Product x*20159 to 4-bit code: ((p >>> 16) + 32) >>> 6, low 4 bits only
  function automatic logic [3:0] compress_nibble(input logic signed [31:0] p);
    logic [9:0] s;
    s = p[25:16] + CompRound;
    return s[9:6];
  endfunction

endpackage

// File: rtl/kyber_coeff_compress_codec_top.sv
// Kyber coefficient codec: compress to 4 bits, decompress, message encode and
// message decode, one packed byte per item. busy_o is always low: an item is
// taken on every cycle that start_i is high, and its result shows on valid_o
// for one cycle only, once it has passed all three stages. The receiver
// cannot stall, so the pipeline (input register, multiply, pack) never holds.
module kyber_coeff_compress_codec_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  byte_in_i,
  input  logic signed [15:0] coeff_in_0_i,
  input  logic signed [15:0] coeff_in_1_i,
  input  logic signed [15:0] coeff_in_2_i,
  input  logic signed [15:0] coeff_in_3_i,
  input  logic signed [15:0] coeff_in_4_i,
  input  logic signed [15:0] coeff_in_5_i,
  input  logic signed [15:0] coeff_in_6_i,
  input  logic signed [15:0] coeff_in_7_i,
  output logic        valid_o,
  output logic [7:0]  byte_out_o,
  output logic [11:0] coeff_out_0_o,
  output logic [11:0] coeff_out_1_o,
  output logic [11:0] coeff_out_2_o,
  output logic [11:0] coeff_out_3_o,
  output logic [11:0] coeff_out_4_o,
  output logic [11:0] coeff_out_5_o,
  output logic [11:0] coeff_out_6_o,
  output logic [11:0] coeff_out_7_o
);
  import kcc_pkg::*;

  logic accept;

  // Stage 1: input register
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [7:0]         s1_byte_q;
  logic signed [15:0] s1_coeff_q [NumCoeff];

  // Stage 2: products, message bits, decoded nibbles
  logic               s2_valid_q;
  op_e                s2_op_q;
  logic [7:0]         s2_byte_q;
  logic signed [31:0] s2_prod_q [2];
  logic signed [31:0] s2_prod_d [2];
  logic [7:0]         s2_msg_q;
  logic [7:0]         s2_msg_d;
  logic [11:0]        s2_dec_q [2];
  logic [11:0]        s2_dec_d [2];

  // Stage 3: output register
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic [7:0]         out_byte_d;
  logic [11:0]        out_coeff_q [NumCoeff];
  logic [11:0]        out_coeff_d [NumCoeff];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= op_e'(op_i);
      s1_byte_q     <= byte_in_i;
      s1_coeff_q[0] <= coeff_in_0_i;
      s1_coeff_q[1] <= coeff_in_1_i;
      s1_coeff_q[2] <= coeff_in_2_i;
      s1_coeff_q[3] <= coeff_in_3_i;
      s1_coeff_q[4] <= coeff_in_4_i;
      s1_coeff_q[5] <= coeff_in_5_i;
      s1_coeff_q[6] <= coeff_in_6_i;
      s1_coeff_q[7] <= coeff_in_7_i;
    end
  end

  // Multiply for compress, message bits, nibble decompress
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      s2_prod_d[k] = 32'(s1_coeff_q[k]) * $signed(32'(CompMult));
    end
    for (int j = 0; j < NumCoeff; j++) begin
      s2_msg_d[j] = msg_bit(s1_coeff_q[j]);
    end
    s2_dec_d[0] = decompress4(s1_byte_q[3:0]);
    s2_dec_d[1] = decompress4(s1_byte_q[7:4]);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_op_q   <= s1_op_q;
      s2_byte_q <= s1_byte_q;
      s2_prod_q <= s2_prod_d;
      s2_msg_q  <= s2_msg_d;
      s2_dec_q  <= s2_dec_d;
    end
  end

  // Round, pack and select per op
  always_comb begin
    out_byte_d = '0;
    for (int j = 0; j < NumCoeff; j++) begin
      out_coeff_d[j] = '0;
    end
    case (s2_op_q)
      OpCompress: begin
        out_byte_d = {compress_nibble(s2_prod_q[1]), compress_nibble(s2_prod_q[0])};
      end
      OpDecompress: begin
        out_coeff_d[0] = s2_dec_q[0];
        out_coeff_d[1] = s2_dec_q[1];
      end
      OpMsgEncode: begin
        out_byte_d = s2_msg_q;
      end
      OpMsgDecode: begin
        for (int j = 0; j < NumCoeff; j++) begin
          out_coeff_d[j] = s2_byte_q[j] ? MsgHalf : 12'd0;
        end
      end
      default: begin
        out_byte_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      out_byte_q  <= out_byte_d;
      out_coeff_q <= out_coeff_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign byte_out_o    = out_byte_q;
  assign coeff_out_0_o = out_coeff_q[0];
  assign coeff_out_1_o = out_coeff_q[1];
  assign coeff_out_2_o = out_coeff_q[2];
  assign coeff_out_3_o = out_coeff_q[3];
  assign coeff_out_4_o = out_coeff_q[4];
  assign coeff_out_5_o = out_coeff_q[5];
  assign coeff_out_6_o = out_coeff_q[6];
  assign coeff_out_7_o = out_coeff_q[7];

endmodule

// File: rtl/kcc_checker.sv
module kcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [7:0]  byte_out_o,
  input logic [11:0] coeff_out_0_o,
  input logic [11:0] coeff_out_1_o,
  input logic [11:0] coeff_out_2_o,
  input logic [11:0] coeff_out_3_o
);
  import kcc_pkg::*;

  // Never holds off an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  // Every transfer in gives one result on valid_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 valid_o)
    else $error("result missing");

  // No result without a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result invented");

  // A nonzero packed byte comes only with coefficients 0 to 3 all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && byte_out_o != 8'd0) |->
      (coeff_out_0_o == 12'd0 && coeff_out_1_o == 12'd0 &&
       coeff_out_2_o == 12'd0 && coeff_out_3_o == 12'd0))
    else $error("byte and coefficients both set");

  // Coefficient 2 is only ever zero or the message decode level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (coeff_out_2_o == 12'd0 || coeff_out_2_o == MsgHalf))
    else $error("bad upper coefficient");

endmodule

bind kyber_coeff_compress_codec_top kcc_checker u_kcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .valid_o       (valid_o),
  .byte_out_o    (byte_out_o),
  .coeff_out_0_o (coeff_out_0_o),
  .coeff_out_1_o (coeff_out_1_o),
  .coeff_out_2_o (coeff_out_2_o),
  .coeff_out_3_o (coeff_out_3_o)
);
